// File: rtl/ftkd_pkg.sv
// ftkd_pkg: shared types and constants of the filtered top-k distinct block
// no dependencies; used by the interfaces, the cell, the chain and the top level
`default_nettype none

package ftkd_pkg;

  localparam int TOP_K     = 10;
  localparam int KEY_W     = 64;
  localparam int PLAT_W    = 8;
  localparam int RATE_W    = 10;
  localparam int YEAR_W    = 12;
  localparam int RANK_W    = 4;
  localparam int CNT_W     = $clog2(TOP_K + 1);
  localparam int IDX_W     = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = YEAR_W'(2004);

  localparam logic KIND_OFFER  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]  title;
    logic [PLAT_W-1:0] plat;
    logic [RATE_W-1:0] rating;
    logic [YEAR_W-1:0] year;
  } entry_t;

  // status a cell hands to the cell below it
  typedef struct packed {
    logic ge;           // cell holds an entry rated at least the offered rating
    logic match_above;  // title hit in this cell or any cell above
  } link_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RPT  = 2'b10
  } state_t;

endpackage

`default_nettype wire

// File: rtl/ftkd_in_if.sv
// ftkd_in_if: input channel, valid/ready plus one record or report request
// depends on ftkd_pkg for field widths
`default_nettype none

interface ftkd_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [ftkd_pkg::KEY_W-1:0]  title_key;
  logic [ftkd_pkg::PLAT_W-1:0] platform_code;
  logic [ftkd_pkg::RATE_W-1:0] rating;
  logic [ftkd_pkg::YEAR_W-1:0] release_year;

  modport source (output valid, kind, title_key, platform_code, rating, release_year,
                  input ready);
  modport sink   (input valid, kind, title_key, platform_code, rating, release_year,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/ftkd_out_if.sv
// ftkd_out_if: result channel, valid/ready plus one ranked entry
// depends on ftkd_pkg for field widths
`default_nettype none

interface ftkd_out_if;
  logic                       valid;
  logic                       ready;
  logic [ftkd_pkg::RANK_W-1:0] rank;
  logic [ftkd_pkg::KEY_W-1:0]  out_title_key;
  logic [ftkd_pkg::PLAT_W-1:0] out_platform_code;
  logic [ftkd_pkg::RATE_W-1:0] out_rating;
  logic [ftkd_pkg::YEAR_W-1:0] out_release_year;
  logic                       entry_valid;
  logic                       last;

  modport source (output valid, rank, out_title_key, out_platform_code, out_rating,
                  out_release_year, entry_valid, last, input ready);
  modport sink   (input valid, rank, out_title_key, out_platform_code, out_rating,
                  out_release_year, entry_valid, last, output ready);
endinterface

`default_nettype wire

// File: rtl/ftkd_cell.sv
// ftkd_cell: one list slot; keeps its entry, loads the offered record or
// takes the entry of the slot above. depends on ftkd_pkg
`default_nettype none

module ftkd_cell (
  input  wire logic            clk,
  input  wire logic            slot_valid,
  input  wire logic            upd,
  input  wire ftkd_pkg::entry_t new_ent,
  input  wire ftkd_pkg::entry_t prev_ent,
  input  wire ftkd_pkg::link_t  link_in,
  output ftkd_pkg::link_t      link_out,
  output logic                 kill,
  output ftkd_pkg::entry_t     ent
);

  ftkd_pkg::entry_t ent_r, ent_nxt;
  logic hit, load, shift;

  always_comb begin
    link_out.ge          = slot_valid && (ent_r.rating >= new_ent.rating);
    hit                  = slot_valid && (ent_r.title == new_ent.title);
    kill                 = hit && (new_ent.rating <= ent_r.rating);
    link_out.match_above = link_in.match_above || hit;
    // first slot not outranking the record takes it, slots below it move down
    // as far as the old copy of the same title
    load  = upd && !link_out.ge && link_in.ge;
    shift = upd && !link_out.ge && !link_in.ge && !link_in.match_above;
    if (load) begin
      ent_nxt = new_ent;
    end else if (shift) begin
      ent_nxt = prev_ent;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

// File: rtl/ftkd_chain.sv
// ftkd_chain: row of TOP_K list cells and the entry count
// depends on ftkd_pkg and ftkd_cell
`default_nettype none

module ftkd_chain (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        offer_fire,
  input  wire ftkd_pkg::entry_t            new_ent,
  input  wire logic [ftkd_pkg::YEAR_W-1:0] min_year,
  output logic [ftkd_pkg::CNT_W-1:0]       count,
  output ftkd_pkg::entry_t                 ents [ftkd_pkg::TOP_K]
);

  logic [ftkd_pkg::CNT_W-1:0] count_r, count_nxt;
  ftkd_pkg::link_t            links [ftkd_pkg::TOP_K+1];
  logic [ftkd_pkg::TOP_K-1:0] kills;
  logic                       drop, upd;

  // virtual slot above the first cell outranks everything
  assign links[0].ge          = 1'b1;
  assign links[0].match_above = 1'b0;

  for (genvar i = 0; i < ftkd_pkg::TOP_K; i++) begin : g_cell
    ftkd_pkg::entry_t prev_ent;
    if (i == 0) begin : g_first
      assign prev_ent = new_ent;
    end else begin : g_rest
      assign prev_ent = ents[i-1];
    end
    ftkd_cell u_cell (
      .clk        (clk),
      .slot_valid (count_r > ftkd_pkg::CNT_W'(i)),
      .upd        (upd),
      .new_ent    (new_ent),
      .prev_ent   (prev_ent),
      .link_in    (links[i]),
      .link_out   (links[i+1]),
      .kill       (kills[i]),
      .ent        (ents[i])
    );
  end

  always_comb begin
    drop = (new_ent.year < min_year) || (|kills);
    upd  = offer_fire && !drop;
    count_nxt = count_r;
    // a replaced title keeps the count, a new title grows it until full
    if (upd && !links[ftkd_pkg::TOP_K].match_above &&
        (count_r < ftkd_pkg::CNT_W'(ftkd_pkg::TOP_K))) begin
      count_nxt = count_r + ftkd_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

`default_nettype wire

// File: rtl/filtered_top_k_distinct_top.sv
// filtered_top_k_distinct_top: ranked top-k list of distinct titles with year filter
// depends on ftkd_pkg, ftkd_in_if, ftkd_out_if and ftkd_chain
//
//   channel  direction  handshake         beat
//   in_ch    in         valid/ready       offer (kind 0) or report request (kind 1)
//   out_ch   out        valid/ready       one ranked entry, last on the final one
//   cfg_*    in         write enable      min_year, taken at once
//
// an offer is placed by the cell row in the same edge it is accepted
// a report holds off input while it sends count beats (one on an empty list),
// one beat per cycle through the output register, as fast as out_ch.ready allows
// the report walks the cells through a read index, so input reopens after the
// cycle that loads the last beat
// reset empties the list and restores min_year to 2004; entry slots are not cleared
`default_nettype none

module filtered_top_k_distinct_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  ftkd_in_if.sink                          in_ch,
  ftkd_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [ftkd_pkg::YEAR_W-1:0] cfg_wdata
);

  logic [ftkd_pkg::YEAR_W-1:0] min_year_r;
  ftkd_pkg::state_t            state_r, state_nxt;
  logic [ftkd_pkg::IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic                        out_vld_r, out_vld_nxt;
  ftkd_pkg::entry_t            out_ent_r, out_ent_nxt;
  logic [ftkd_pkg::RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic                        out_ev_r, out_ev_nxt;
  logic                        out_last_r, out_last_nxt;

  ftkd_pkg::entry_t            new_ent;
  ftkd_pkg::entry_t            ents [ftkd_pkg::TOP_K];
  logic [ftkd_pkg::CNT_W-1:0]  count;
  logic [ftkd_pkg::CNT_W-1:0]  idx_ext;
  logic                        in_fire, offer_fire, load, is_last;

  assign in_ch.ready = (state_r == ftkd_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign offer_fire  = in_fire && (in_ch.kind == ftkd_pkg::KIND_OFFER);

  assign new_ent.title  = in_ch.title_key;
  assign new_ent.plat   = in_ch.platform_code;
  assign new_ent.rating = in_ch.rating;
  assign new_ent.year   = in_ch.release_year;

  ftkd_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .offer_fire (offer_fire),
    .new_ent    (new_ent),
    .min_year   (min_year_r),
    .count      (count),
    .ents       (ents)
  );

  always_comb begin
    idx_ext   = ftkd_pkg::CNT_W'(rd_idx_r);
    is_last   = (count == '0) || ((idx_ext + ftkd_pkg::CNT_W'(1)) == count);
    load      = (state_r == ftkd_pkg::ST_RPT) && (!out_vld_r || out_ch.ready);
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_ent_nxt  = out_ent_r;
    out_rank_nxt = out_rank_r;
    out_ev_nxt   = out_ev_r;
    out_last_nxt = out_last_r;
    case (state_r)
      ftkd_pkg::ST_IDLE: begin
        if (in_fire && (in_ch.kind == ftkd_pkg::KIND_REPORT)) begin
          state_nxt  = ftkd_pkg::ST_RPT;
          rd_idx_nxt = '0;
        end
      end
      ftkd_pkg::ST_RPT: begin
        if (load) begin
          out_vld_nxt = 1'b1;
          out_last_nxt = is_last;
          if (count == '0) begin
            out_ent_nxt  = '0;
            out_rank_nxt = '0;
            out_ev_nxt   = 1'b0;
          end else begin
            out_ent_nxt  = ents[rd_idx_r];
            out_rank_nxt = ftkd_pkg::RANK_W'(idx_ext + ftkd_pkg::CNT_W'(1));
            out_ev_nxt   = 1'b1;
          end
          rd_idx_nxt = rd_idx_r + ftkd_pkg::IDX_W'(1);
          if (is_last) begin
            state_nxt = ftkd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ftkd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ftkd_pkg::ST_IDLE;
      out_vld_r  <= 1'b0;
      min_year_r <= ftkd_pkg::MIN_YEAR_RESET;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        min_year_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    out_ent_r  <= out_ent_nxt;
    out_rank_r <= out_rank_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.rank              = out_rank_r;
  assign out_ch.out_title_key     = out_ent_r.title;
  assign out_ch.out_platform_code = out_ent_r.plat;
  assign out_ch.out_rating        = out_ent_r.rating;
  assign out_ch.out_release_year  = out_ent_r.year;
  assign out_ch.entry_valid       = out_ev_r;
  assign out_ch.last              = out_last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count <= ftkd_pkg::CNT_W'(ftkd_pkg::TOP_K))
    else $error("entry count above list size");

  a_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ftkd_pkg::ST_RPT) |=> $stable(count))
    else $error("list changed during a report");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ev_r) |-> out_last_r)
    else $error("empty-list beat without last");

  a_last_ends_report: assert property (@(posedge clk) disable iff (!rst_n)
    (load && is_last) |=> (state_r == ftkd_pkg::ST_IDLE))
    else $error("report did not end after its last beat");

endmodule

`default_nettype wire

// File: tb/tb_filtered_top_k_distinct_top.sv
// tb_filtered_top_k_distinct_top: self-checking bench for the ranked top-k distinct-title list
// depends on ftkd_pkg, ftkd_in_if, ftkd_out_if and filtered_top_k_distinct_top; keeps its own
// copy of the ranked list to predict every report beat

module tb_filtered_top_k_distinct_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ftkd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int POOL_SIZE = 24;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [KEY_W-1:0]  title;
    logic [PLAT_W-1:0] plat;
    logic [RATE_W-1:0] rating;
    logic [YEAR_W-1:0] year;
    logic              entry_valid;
    logic              last;
  } ranked_beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [YEAR_W-1:0] cfg_wdata;

  ftkd_in_if  in_ch();
  ftkd_out_if out_ch();

  filtered_top_k_distinct_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predicted state of the block
  entry_t            ranked_list[$];
  logic [YEAR_W-1:0] floor_year = MIN_YEAR_RESET;
  ranked_beat_t      pending_beats[$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [KEY_W-1:0] title_pool[POOL_SIZE];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void rank_offer(entry_t rec);
    int pos;
    int i;
    bit found;
    if (rec.year < floor_year) return;
    found = 1'b0;
    for (i = 0; i < ranked_list.size() && !found; i++) begin
      if (ranked_list[i].title == rec.title) begin
        found = 1'b1;
        if (rec.rating <= ranked_list[i].rating) return;
        ranked_list.delete(i);
      end
    end
    // first slot rated strictly lower, so ties stay in arrival order
    pos = ranked_list.size();
    found = 1'b0;
    for (i = 0; i < ranked_list.size() && !found; i++) begin
      if (ranked_list[i].rating < rec.rating) begin
        pos = i;
        found = 1'b1;
      end
    end
    if (pos >= TOP_K) return;
    ranked_list.insert(pos, rec);
    if (ranked_list.size() > TOP_K) void'(ranked_list.pop_back());
  endfunction

  function automatic void expect_report();
    ranked_beat_t b;
    b = '0;
    if (ranked_list.size() == 0) begin
      b.last = 1'b1;
      pending_beats.push_back(b);
    end else begin
      for (int k = 0; k < ranked_list.size(); k++) begin
        b.rank        = RANK_W'(k + 1);
        b.title       = ranked_list[k].title;
        b.plat        = ranked_list[k].plat;
        b.rating      = ranked_list[k].rating;
        b.year        = ranked_list[k].year;
        b.entry_valid = 1'b1;
        b.last        = (k == ranked_list.size() - 1);
        pending_beats.push_back(b);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_beat
    ranked_beat_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: beat expected none actual rank %0h title %0h", $time, out_ch.rank,
                 out_ch.out_title_key);
        error_count++;
      end else begin
        want = pending_beats.pop_front();
        check_field("rank", want.rank, out_ch.rank);
        check_field("out_title_key", want.title, out_ch.out_title_key);
        check_field("out_platform_code", want.plat, out_ch.out_platform_code);
        check_field("out_rating", want.rating, out_ch.out_rating);
        check_field("out_release_year", want.year, out_ch.out_release_year);
        check_field("entry_valid", want.entry_valid, out_ch.entry_valid);
        check_field("last", want.last, out_ch.last);
      end
    end
  end

  // called right after a rising edge; returns at the edge the beat is taken
  task automatic send_beat(input logic kind, input logic [KEY_W-1:0] title,
                           input logic [PLAT_W-1:0] plat, input logic [RATE_W-1:0] rating,
                           input logic [YEAR_W-1:0] year);
    int gap;
    entry_t rec;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.title_key     <= title;
    in_ch.platform_code <= plat;
    in_ch.rating        <= rating;
    in_ch.release_year  <= year;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    rec.title  = title;
    rec.plat   = plat;
    rec.rating = rating;
    rec.year   = year;
    if (kind == KIND_REPORT) expect_report();
    else rank_offer(rec);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    // an offer may still be in flight after the last report beat
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_year(input logic [YEAR_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    floor_year = value;
    cfg_we <= 1'b0;
  endtask

  task automatic test_empty_report();
    send_beat(KIND_REPORT, '1, '1, '1, '1);
  endtask

  task automatic test_year_filter();
    send_beat(KIND_OFFER, 64'h1111, 8'h01, 10'd700, 12'd2003);
    send_beat(KIND_OFFER, 64'h2222, 8'h02, 10'd300, 12'd2004);
    send_beat(KIND_OFFER, '1, 8'hff, 10'd1023, 12'd4095);
    send_beat(KIND_OFFER, 64'h0, 8'h00, 10'd0, 12'd2004);
    send_beat(KIND_REPORT, 64'h0, 8'h00, 10'd0, 12'd0);
  endtask

  task automatic test_repeat_title();
    logic [KEY_W-1:0] key;
    key = 64'hA5A5_0000_0000_5A5A;
    send_beat(KIND_OFFER, key, 8'h10, 10'd500, 12'd2010);
    send_beat(KIND_OFFER, key, 8'h11, 10'd400, 12'd2011);
    send_beat(KIND_OFFER, key, 8'h12, 10'd500, 12'd2012);
    send_beat(KIND_OFFER, key, 8'h13, 10'd600, 12'd2013);
    send_beat(KIND_REPORT, 64'h5555, 8'h55, 10'd55, 12'd55);
  endtask

  task automatic test_full_list();
    // equal ratings must come out in arrival order
    for (int i = 0; i < 6; i++)
      send_beat(KIND_OFFER, 64'h7000 + i, 8'(8'h20 + i), 10'd700, 12'd2020);
    // ties with the lowest entry of a full list do not get in
    send_beat(KIND_OFFER, 64'h8000, 8'h30, 10'd0, 12'd2020);
    send_beat(KIND_OFFER, 64'h8001, 8'h31, 10'd1, 12'd2021);
    send_beat(KIND_REPORT, 64'h0, 8'h00, 10'd0, 12'd0);
  endtask

  task automatic test_min_year_limits();
    write_min_year(12'd0);
    send_beat(KIND_OFFER, 64'h9000, 8'h40, 10'd800, 12'd0);
    write_min_year(12'd4095);
    send_beat(KIND_OFFER, 64'h9001, 8'h41, 10'd950, 12'd4094);
    send_beat(KIND_OFFER, 64'h9002, 8'h42, 10'd900, 12'd4095);
    send_beat(KIND_REPORT, 64'h0, 8'h00, 10'd0, 12'd0);
  endtask

  task automatic test_random();
    int send_pct[4];
    int recv_pct[4];
    logic [YEAR_W-1:0] floors[4];
    logic [KEY_W-1:0] key;
    logic [RATE_W-1:0] rating;
    logic [YEAR_W-1:0] year;
    int base;
    int lo;
    int hi;
    send_pct = '{0, 55, 0, 29};
    recv_pct = '{0, 0, 55, 29};
    floors   = '{12'd2004, 12'd1985, 12'd2030, 12'd4000};
    foreach (title_pool[i]) title_pool[i] = {$urandom, $urandom};
    for (int p = 0; p < 4; p++) begin
      write_min_year(floors[p]);
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      // the list never empties, so each phase rates higher to keep it moving
      base = 250 * p;
      lo = (floor_year > 15) ? floor_year - 15 : 0;
      hi = (floor_year < 4080) ? floor_year + 15 : 4095;
      for (int n = 0; n < 100; n++) begin
        if (p == 1 && n == 50) drain_results();
        if ($urandom_range(7) == 0) begin
          send_beat(KIND_REPORT, {$urandom, $urandom}, 8'($urandom), 10'($urandom),
                    12'($urandom));
        end else begin
          key = ($urandom_range(3) != 0) ? title_pool[$urandom_range(POOL_SIZE - 1)]
                                         : {$urandom, $urandom};
          case ($urandom_range(9))
            0:       rating = 10'($urandom_range(1023));
            1, 2:    rating = 10'($urandom_range(base + 190, base + 200));
            default: rating = 10'($urandom_range(base, base + 200));
          endcase
          year = ($urandom_range(4) == 0) ? 12'($urandom_range(4095))
                                          : 12'($urandom_range(lo, hi));
          send_beat(KIND_OFFER, key, 8'($urandom_range(255)), rating, year);
        end
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_OFFER;
    in_ch.title_key     = '0;
    in_ch.platform_code = '0;
    in_ch.rating        = '0;
    in_ch.release_year  = '0;
    out_ch.ready        = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_report();
    test_year_filter();
    test_repeat_title();
    test_full_list();
    test_min_year_limits();
    test_random();

    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
